// ----- rtl/core/b64enc_pkg.sv -----
// ----------------------------------------------------------------------------
// b64enc_pkg
// Shared types, constants and the symbol map of the streaming base64 encoder.
// ----------------------------------------------------------------------------
package b64enc_pkg;

    // width of the per-job result counts and default queue depth
    localparam int STEP_W          = 3;
    localparam int QUEUE_DEPTH_DEF = 2;

    // ascii codes used outside the symbol map
    localparam logic [6:0] CHAR_PAD  = 7'h3D;   // '='
    localparam logic [6:0] CHAR_NL   = 7'h0A;   // newline
    localparam logic [6:0] CHAR_NONE = 7'h00;   // error result

    // job handed from front to back: up to three bytes left aligned,
    // number of symbols, number of results and the char that fills the rest
    typedef struct packed {
        logic [23:0]       bits;
        logic [STEP_W-1:0] nsym;
        logic [STEP_W-1:0] ntot;
        logic [6:0]        tail;
        logic              err;
        logic              last;
    } t_job;

    // 6-bit value to its base64 symbol
    function automatic logic [6:0] sym(input logic [5:0] v);
        logic [6:0] w;
        begin
            w = {1'b0, v};
            if (v < 6'd26) begin
                sym = 7'h41 + w;            // A..Z
            end else if (v < 6'd52) begin
                sym = 7'h47 + w;            // a..z
            end else if (v < 6'd62) begin
                sym = w - 7'd4;             // 0..9
            end else if (v == 6'd62) begin
                sym = 7'h2B;                // +
            end else begin
                sym = 7'h2F;                // /
            end
        end
    endfunction

endpackage

// ----- rtl/core/b64enc_in_if.sv -----
// ----------------------------------------------------------------------------
// b64enc_in_if
// Byte channel into the encoder: one message byte and its end flag per item.
// ----------------------------------------------------------------------------
interface b64enc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// ----- rtl/core/b64enc_out_if.sv -----
// ----------------------------------------------------------------------------
// b64enc_out_if
// Character channel out of the encoder: one ascii char and its flags per item.
// ----------------------------------------------------------------------------
interface b64enc_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] out_char;
    logic       last_char;
    logic       length_error;

    modport source (output valid, output out_char, output last_char,
                    output length_error, input ready);
    modport sink   (input valid, input out_char, input last_char,
                    input length_error, output ready);
endinterface

// ----- rtl/core/b64enc_cfg_if.sv -----
// ----------------------------------------------------------------------------
// b64enc_cfg_if
// Configuration write channel carrying the line mode bit.
// ----------------------------------------------------------------------------
interface b64enc_cfg_if;
    logic valid;
    logic ready;
    logic data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/core/base64_stream_encoder_top.sv -----
// a byte that finishes a group or a message is pushed as a job into the queue; its first
// char then enters the output register; a byte that only joins a group yields nothing
// throughput: one byte per cycle while the job queue has room; chars leave at one per
// cycle through the single output register while the sink is ready
// reset: synchronous active-low i_rst_n clears held bytes, queue, step counter, output
// valid and line mode (normal padding); no clearing pass
// ----------------------------------------------------------------------------
// base64_stream_encoder_top
// Streaming base64 encoder with padding or newline/length check at message end.
// ----------------------------------------------------------------------------
module base64_stream_encoder_top
    import b64enc_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    b64enc_in_if.sink            i_in,
    b64enc_out_if.source         o_out,
    b64enc_cfg_if.sink           i_cfg
);

    logic r_line_mode;
    logic push;
    logic pop;
    logic queue_full;
    logic job_valid;
    t_job front_job;
    t_job head_job;

    // line mode register
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_mode <= 1'b0;
        end else if (i_cfg.valid) begin
            r_line_mode <= i_cfg.data;
        end
    end

    // byte grouping and classification
    b64enc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in.valid),
        .i_data_byte  (i_in.data_byte),
        .i_last_byte  (i_in.last_byte),
        .o_ready      (i_in.ready),
        .i_line_mode  (r_line_mode),
        .i_queue_full (queue_full),
        .o_push       (push),
        .o_job        (front_job)
    );

    // job queue
    b64enc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .o_full  (queue_full),
        .i_pop   (pop),
        .o_valid (job_valid),
        .o_head  (head_job)
    );

    // character generation
    b64enc_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_job_valid    (job_valid),
        .i_job          (head_job),
        .o_pop          (pop),
        .o_valid        (o_out.valid),
        .i_ready        (o_out.ready),
        .o_out_char     (o_out.out_char),
        .o_last_char    (o_out.last_char),
        .o_length_error (o_out.length_error)
    );

endmodule

// ----- rtl/core/b64enc_front.sv -----
// ----------------------------------------------------------------------------
// b64enc_front
// Accepts bytes, groups them in threes and turns each finished group or
// message end into one job for the character back end.
// ----------------------------------------------------------------------------
module b64enc_front
    import b64enc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    output logic       o_ready,
    input  logic       i_line_mode,
    input  logic       i_queue_full,
    output logic       o_push,
    output t_job       o_job
);

    logic [15:0] r_held_bytes;
    logic [1:0]  r_held_count;
    logic [15:0] n_held_bytes;
    logic [1:0]  n_held_count;
    logic [1:0]  cnt;
    logic        accept;
    logic        full_group;

    assign o_ready = !i_queue_full;
    assign accept  = i_valid && o_ready;

    // a count of three cannot arise, treated as two
    assign cnt        = (r_held_count == 2'd3) ? 2'd2 : r_held_count;
    assign full_group = (cnt == 2'd2);

    // classify the item and build its job
    always_comb begin
        o_job        = '0;
        o_push       = 1'b0;
        n_held_bytes = r_held_bytes;
        n_held_count = r_held_count;
        if (accept) begin
            n_held_bytes = '0;
            n_held_count = '0;
            if (full_group) begin
                o_push      = 1'b1;
                o_job.bits  = {r_held_bytes, i_data_byte};
                o_job.nsym  = STEP_W'(4);
                o_job.ntot  = (i_last_byte && i_line_mode) ? STEP_W'(5) : STEP_W'(4);
                o_job.tail  = CHAR_NL;
                o_job.last  = i_last_byte;
            end else if (!i_last_byte) begin
                n_held_bytes = {r_held_bytes[7:0], i_data_byte};
                n_held_count = cnt + 2'd1;
            end else if (i_line_mode) begin
                o_push      = 1'b1;
                o_job.ntot  = STEP_W'(1);
                o_job.tail  = CHAR_NONE;
                o_job.err   = 1'b1;
                o_job.last  = 1'b1;
            end else if (cnt == 2'd0) begin
                o_push      = 1'b1;
                o_job.bits  = {i_data_byte, 16'h0000};
                o_job.nsym  = STEP_W'(2);
                o_job.ntot  = STEP_W'(4);
                o_job.tail  = CHAR_PAD;
                o_job.last  = 1'b1;
            end else begin
                o_push      = 1'b1;
                o_job.bits  = {r_held_bytes[7:0], i_data_byte, 8'h00};
                o_job.nsym  = STEP_W'(3);
                o_job.ntot  = STEP_W'(4);
                o_job.tail  = CHAR_PAD;
                o_job.last  = 1'b1;
            end
        end
    end

    // pending bytes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_bytes <= '0;
            r_held_count <= '0;
        end else begin
            r_held_bytes <= n_held_bytes;
            r_held_count <= n_held_count;
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held_count != 2'd3)
        else $error("held count reached three");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_last_byte |=> r_held_count == 2'd0)
        else $error("held bytes not cleared after message end");

endmodule

// ----- rtl/core/b64enc_queue.sv -----
// ----------------------------------------------------------------------------
// b64enc_queue
// Short job queue between the front and the back end.
// ----------------------------------------------------------------------------
module b64enc_queue
    import b64enc_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_job o_head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("job pushed into a full queue");

endmodule

// ----- rtl/core/b64enc_back.sv -----
// ----------------------------------------------------------------------------
// b64enc_back
// Walks each job into the output register, one result per cycle unless stalled.
// ----------------------------------------------------------------------------
module b64enc_back
    import b64enc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_job_valid,
    input  t_job       i_job,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [6:0] o_out_char,
    output logic       o_last_char,
    output logic       o_length_error
);

    logic [STEP_W-1:0] r_step;
    logic              r_out_valid;
    logic [6:0]        r_out_char;
    logic              r_last_char;
    logic              r_length_error;
    logic              load;
    logic              final_step;
    logic [5:0]        field;
    logic [6:0]        n_char;

    assign load       = i_job_valid && (!r_out_valid || i_ready);
    assign final_step = (r_step == i_job.ntot - STEP_W'(1));
    assign o_pop      = load && final_step;

    // pick the six bits for the current symbol
    always_comb begin
        case (r_step)
            STEP_W'(0): field = i_job.bits[23:18];
            STEP_W'(1): field = i_job.bits[17:12];
            STEP_W'(2): field = i_job.bits[11:6];
            default:    field = i_job.bits[5:0];
        endcase
        n_char = (r_step < i_job.nsym) ? sym(field) : i_job.tail;
    end

    // step counter within the job
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
        end else if (load) begin
            r_step <= final_step ? '0 : r_step + STEP_W'(1);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_char     <= n_char;
            r_last_char    <= i_job.last && final_step;
            r_length_error <= i_job.err;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_out_char     = r_out_char;
    assign o_last_char    = r_last_char;
    assign o_length_error = r_length_error;

    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_job_valid |-> r_step < i_job.ntot)
        else $error("step counter ran past the job");

    a_err_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_length_error |-> r_last_char && r_out_char == CHAR_NONE)
        else $error("malformed length error item");

endmodule
